// ===== hdl/pr_grid_current_controller_macros.svh =====
// Assertion macros for the grid current controller.
// Included by pr_grid_current_controller.sv, which carries concurrent checks; needs nothing else.
`ifndef PR_GRID_CURRENT_CONTROLLER_MACROS_SVH
`define PR_GRID_CURRENT_CONTROLLER_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define PRGC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define PRGC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PRGC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PRGC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/prgc_pkg.sv =====
// Package of the grid current controller: multiplier sizes, sequencer steps,
// register indexes and fixed-point constants. Depends on nothing.
`timescale 1ns / 1ps
package prgc_pkg;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 48;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_N_W = 6;

  typedef struct packed {
    logic                start;
    logic [MUL_N_W-1:0]  nbits;
  } mul_req_t;

  typedef enum logic [3:0] {
    SP_Z2, SP_ZC, SP_ZT, SP_ZF,
    SP_R0, SP_R1, SP_R2, SP_R3,
    SP_W0, SP_W1, SP_W2,
    SP_A0, SP_A1, SP_A2, SP_A3
  } step_e;

  localparam logic [1:0] REG_PROP_GAIN = 2'd0;
  localparam logic [1:0] REG_RES_GAIN  = 2'd1;
  localparam logic [1:0] REG_PERIOD    = 2'd2;
  localparam logic [1:0] REG_MAX_STEP  = 2'd3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [16:0] SIN_A      = 17'd102944;
  localparam logic [15:0] SIN_B      = 16'd42048;
  localparam logic [12:0] SIN_C      = 13'd4640;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [21:0] FOUR_PI_SQ = 22'd2587258;

endpackage

// ===== hdl/prgc_serial_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on prgc_pkg.
`timescale 1ns / 1ps
module prgc_serial_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  prgc_pkg::mul_req_t             req_i,
  input  logic [prgc_pkg::MUL_A_W-1:0]   a_i,
  input  logic [prgc_pkg::MUL_B_W-1:0]   b_i,
  output logic                           done_o,
  output logic [prgc_pkg::MUL_P_W-1:0]   prod_o
);

  logic [prgc_pkg::MUL_A_W-1:0] a_q;
  logic [prgc_pkg::MUL_B_W-1:0] b_q;
  logic [prgc_pkg::MUL_P_W-1:0] acc_q;
  logic [prgc_pkg::MUL_N_W-1:0] cnt_q;
  logic [prgc_pkg::MUL_N_W-1:0] shamt;

  assign shamt = prgc_pkg::MUL_N_W'(prgc_pkg::MUL_B_W) - req_i.nbits;

  // The multiplier word is left-aligned so that its top bit is always the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.nbits;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i << shamt;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q << 1) +
               (b_q[prgc_pkg::MUL_B_W-1] ? prgc_pkg::MUL_P_W'(a_q) : '0);
      b_q   <= b_q << 1;
    end
  end

  assign done_o = (cnt_q == prgc_pkg::MUL_N_W'(1));
  assign prod_o = acc_q;

endmodule

// ===== hdl/pr_grid_current_controller.sv =====
// Top level of the proportional-resonant grid current controller.
// Depends on prgc_pkg, prgc_serial_mul and pr_grid_current_controller_macros.svh.
`timescale 1ns / 1ps
`include "pr_grid_current_controller_macros.svh"
// One input word yields one voltage word. On acceptance the held d/q reference
// moves toward the desired value and the phase is split into quadrant and fraction;
// then a sequencer runs its steps (quarter-wave sine twice, the rotation, the
// resonance factor and four steps per axis), each feeding one bit-serial multiplier.
// A step issues its multiplication and waits until it is done; the input stays
// stalled until the result has moved into the output register.
// The result sits in an output register, so it can wait for the sink while the
// next word is already accepted. Writing either gain register clears the held
// reference and all four integrators. Configuration is written through the
// APB-style port, register i at byte address 4*i; pready is always high.
module pr_grid_current_controller #(
  parameter int CURRENT_WIDTH = 24,
  parameter int PHASE_WIDTH   = 16,
  parameter int INTEG_WIDTH   = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [CURRENT_WIDTH-1:0] meas_alpha_i,
  input  logic signed [CURRENT_WIDTH-1:0] meas_beta_i,
  input  logic signed [CURRENT_WIDTH-1:0] want_d_i,
  input  logic signed [CURRENT_WIDTH-1:0] want_q_i,
  input  logic [PHASE_WIDTH-1:0]          phase_angle_i,
  input  logic [15:0]                     line_freq_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              volt_alpha_o,
  output logic signed [31:0]              volt_beta_o
);

  localparam int CW    = CURRENT_WIDTH;
  localparam int IW    = INTEG_WIDTH;
  localparam int EW    = CW + 3;
  localparam int RW    = CW + 19;
  localparam int DW    = (CW + 2 > 25) ? CW + 2 : 25;
  localparam int SUM_W = ((IW > CW + 19) ? IW : CW + 19) + 4;
  localparam int PW    = prgc_pkg::MUL_P_W;

  localparam logic signed [SUM_W-1:0] LIM_S =
    $signed((SUM_W'(1) << (IW - 1)) - SUM_W'(1));
  localparam logic signed [SUM_W-1:0] V_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] V_MIN = -V_MAX - SUM_W'(1);
  localparam logic signed [IW-1:0]    I_MIN = $signed({1'b1, {(IW-1){1'b0}}});

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_POST  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // Configuration registers.
  logic [23:0] prop_q, res_q;
  logic [31:0] dt_q;
  logic [22:0] mstep_q;
  logic        cfg_wr;

  state_e              state_q;
  prgc_pkg::step_e     step_q;
  logic                lane_q;

  logic signed [CW-1:0] ref_d_q, ref_q_q;
  logic signed [CW-1:0] meas_q [2];
  logic signed [IW-1:0] fi_q [2];
  logic signed [IW-1:0] si_q [2];
  logic signed [IW-1:0] drive_q;
  logic signed [31:0]   volt_q [2];
  logic signed [31:0]   out_a_q, out_b_q;
  logic                 out_valid_q;

  logic [15:0]          z_q;
  logic [1:0]           quad_q;
  logic [15:0]          freq_q;
  logic [16:0]          z2_q, t2_q, fz_q;
  logic [15:0]          t_q;
  logic signed [17:0]   sn_q, cs_q;
  logic signed [RW-1:0] acc_q;
  logic signed [EW-1:0] ref_a_q, ref_b_q;
  logic [39:0]          w_q;
  logic [45:0]          w2dt_q;
  logic                 neg_q;

  prgc_pkg::mul_req_t         mreq;
  logic [prgc_pkg::MUL_A_W-1:0] mul_a;
  logic [prgc_pkg::MUL_B_W-1:0] mul_b;
  logic                       mul_neg;
  logic                       mul_done;
  logic [PW-1:0]              prod;

  logic                 in_accept;
  logic [16:0]          x_arg;
  logic [21:0]          z_full;
  logic signed [DW-1:0] diff_d, diff_q, ms_s, step_d, step_q_ax;
  logic [CW-1:0]        d_mag, q_mag;
  logic [16:0]          sn_mag, cs_mag;
  logic signed [EW-1:0] err;
  logic [EW-1:0]        err_mag;
  logic [IW-1:0]        drive_mag, fi_mag;
  logic signed [PW:0]   sp;
  logic signed [RW-1:0] acc_n;
  logic [PW-1:0]        sh32, sh24;
  logic signed [SUM_W-1:0] r32, r24, xv, vv;
  logic [16:0]          f_new;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign in_accept = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    unique case (paddr[3:2])
      prgc_pkg::REG_PROP_GAIN: prdata = 32'(prop_q);
      prgc_pkg::REG_RES_GAIN:  prdata = 32'(res_q);
      prgc_pkg::REG_PERIOD:    prdata = dt_q;
      prgc_pkg::REG_MAX_STEP:  prdata = 32'(mstep_q);
      default:                 prdata = '0;
    endcase
  end

  function automatic logic signed [SUM_W-1:0] sat_sym(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > LIM_S) r = LIM_S;
    else if (v < -LIM_S) r = -LIM_S;
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_mag(input logic [PW-1:0] m);
    logic signed [SUM_W-1:0] r;
    r = (m > PW'(LIM_S)) ? LIM_S : $signed(SUM_W'(m));
    return r;
  endfunction

  // Reference slew limit, computed on the accepted word.
  always_comb begin
    ms_s      = $signed(DW'(mstep_q));
    diff_d    = DW'(want_d_i) - DW'(ref_d_q);
    diff_q    = DW'(want_q_i) - DW'(ref_q_q);
    step_d    = (diff_d > ms_s) ? ms_s : ((diff_d < -ms_s) ? -ms_s : diff_d);
    step_q_ax = (diff_q > ms_s) ? ms_s : ((diff_q < -ms_s) ? -ms_s : diff_q);
    z_full    = 22'(phase_angle_i[PHASE_WIDTH-3:0]) << (24 - PHASE_WIDTH);
  end

  // Operand selection for the multiplier; signed operands go in as magnitudes.
  always_comb begin
    x_arg     = lane_q ? (prgc_pkg::ONE_Q16 - {1'b0, z_q}) : {1'b0, z_q};
    d_mag     = ref_d_q[CW-1] ? CW'(-ref_d_q) : CW'(ref_d_q);
    q_mag     = ref_q_q[CW-1] ? CW'(-ref_q_q) : CW'(ref_q_q);
    sn_mag    = sn_q[17] ? 17'(-sn_q) : 17'(sn_q);
    cs_mag    = cs_q[17] ? 17'(-cs_q) : 17'(cs_q);
    err       = (lane_q ? ref_b_q : ref_a_q) - EW'(meas_q[lane_q]);
    err_mag   = err[EW-1] ? EW'(-err) : EW'(err);
    drive_mag = drive_q[IW-1] ? IW'(-drive_q) : IW'(drive_q);
    fi_mag    = fi_q[lane_q][IW-1] ? IW'(-fi_q[lane_q]) : IW'(fi_q[lane_q]);
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    mreq.start = (state_q == ST_ISSUE);
    mreq.nbits = prgc_pkg::MUL_N_W'(17);
    case (step_q)
      prgc_pkg::SP_Z2: begin
        mul_a = 64'(x_arg); mul_b = 48'(x_arg);
      end
      prgc_pkg::SP_ZC: begin
        mul_a = 64'(z2_q); mul_b = 48'(prgc_pkg::SIN_C); mreq.nbits = 6'd13;
      end
      prgc_pkg::SP_ZT: begin
        mul_a = 64'(z2_q); mul_b = 48'(t_q); mreq.nbits = 6'd16;
      end
      prgc_pkg::SP_ZF: begin
        mul_a = 64'(x_arg); mul_b = 48'(t2_q);
      end
      prgc_pkg::SP_R0: begin
        mul_a = 64'(d_mag); mul_b = 48'(cs_mag); mul_neg = ref_d_q[CW-1] ^ cs_q[17];
      end
      prgc_pkg::SP_R1: begin
        mul_a = 64'(q_mag); mul_b = 48'(sn_mag); mul_neg = ref_q_q[CW-1] ^ sn_q[17];
      end
      prgc_pkg::SP_R2: begin
        mul_a = 64'(d_mag); mul_b = 48'(sn_mag); mul_neg = ref_d_q[CW-1] ^ sn_q[17];
      end
      prgc_pkg::SP_R3: begin
        mul_a = 64'(q_mag); mul_b = 48'(cs_mag); mul_neg = ref_q_q[CW-1] ^ cs_q[17];
      end
      prgc_pkg::SP_W0: begin
        mul_a = 64'(freq_q); mul_b = 48'(freq_q); mreq.nbits = 6'd16;
      end
      prgc_pkg::SP_W1: begin
        mul_a = 64'(w_q); mul_b = 48'(dt_q); mreq.nbits = 6'd32;
      end
      prgc_pkg::SP_W2: begin
        mul_a = 64'(w_q); mul_b = 48'(prgc_pkg::FOUR_PI_SQ); mreq.nbits = 6'd22;
      end
      prgc_pkg::SP_A0: begin
        mul_a = 64'(err_mag); mul_b = 48'(res_q); mul_neg = err[EW-1];
        mreq.nbits = 6'd24;
      end
      prgc_pkg::SP_A1: begin
        mul_a = 64'(drive_mag); mul_b = 48'(dt_q); mul_neg = drive_q[IW-1];
        mreq.nbits = 6'd32;
      end
      prgc_pkg::SP_A2: begin
        mul_a = 64'(fi_mag); mul_b = 48'(w2dt_q); mul_neg = fi_q[lane_q][IW-1];
        mreq.nbits = 6'd46;
      end
      prgc_pkg::SP_A3: begin
        mul_a = 64'(err_mag); mul_b = 48'(prop_q); mul_neg = err[EW-1];
        mreq.nbits = 6'd24;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  prgc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  // Post-processing of the finished product.
  always_comb begin
    sp    = neg_q ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    acc_n = acc_q - RW'(sp);
    sh32  = prod >> 32;
    sh24  = prod >> 24;
    r32   = neg_q ? -sat_mag(sh32) : sat_mag(sh32);
    r24   = neg_q ? -sat_mag(sh24) : sat_mag(sh24);
    xv    = SUM_W'(sp >>> 8);
    vv    = xv + SUM_W'(fi_q[lane_q]);
    f_new = prod[32:16];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= prgc_pkg::SP_Z2;
      lane_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prop_q      <= 24'd25600;
      res_q       <= 24'd2048000;
      dt_q        <= 32'd214748;
      mstep_q     <= 23'd410;
      ref_d_q     <= '0;
      ref_q_q     <= '0;
      fi_q[0]     <= '0;
      fi_q[1]     <= '0;
      si_q[0]     <= '0;
      si_q[1]     <= '0;
    end else begin
      // The output register is refilled from the sequencer or emptied by the sink.
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          prgc_pkg::REG_PROP_GAIN: prop_q  <= pwdata[23:0];
          prgc_pkg::REG_RES_GAIN:  res_q   <= pwdata[23:0];
          prgc_pkg::REG_PERIOD:    dt_q    <= pwdata;
          prgc_pkg::REG_MAX_STEP:  mstep_q <= pwdata[22:0];
          default:                 dt_q    <= dt_q;
        endcase
        // A new gain invalidates the controller history.
        if (paddr[3:2] == prgc_pkg::REG_PROP_GAIN || paddr[3:2] == prgc_pkg::REG_RES_GAIN) begin
          ref_d_q <= '0;
          ref_q_q <= '0;
          fi_q[0] <= '0;
          fi_q[1] <= '0;
          si_q[0] <= '0;
          si_q[1] <= '0;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            ref_d_q <= CW'(DW'(ref_d_q) + step_d);
            ref_q_q <= CW'(DW'(ref_q_q) + step_q_ax);
            step_q  <= prgc_pkg::SP_Z2;
            lane_q  <= 1'b0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_q <= ST_MUL;
        ST_MUL: begin
          if (mul_done) state_q <= ST_POST;
        end
        ST_POST: begin
          // The last step of the beta axis ends the sequence.
          state_q <= (step_q == prgc_pkg::SP_A3 && lane_q) ? ST_OUT : ST_ISSUE;
          case (step_q)
            prgc_pkg::SP_Z2, prgc_pkg::SP_ZC, prgc_pkg::SP_ZT: begin
              step_q <= prgc_pkg::step_e'(step_q + 1'b1);
            end
            prgc_pkg::SP_ZF: begin
              if (!lane_q) begin
                lane_q <= 1'b1;
                step_q <= prgc_pkg::SP_Z2;
              end else begin
                lane_q <= 1'b0;
                step_q <= prgc_pkg::SP_R0;
              end
            end
            prgc_pkg::SP_A1: begin
              fi_q[lane_q] <= IW'(sat_sym(SUM_W'(fi_q[lane_q]) + r32));
              step_q <= prgc_pkg::SP_A2;
            end
            prgc_pkg::SP_A2: begin
              si_q[lane_q] <= IW'(sat_sym(SUM_W'(si_q[lane_q]) + r24));
              step_q <= prgc_pkg::SP_A3;
            end
            prgc_pkg::SP_A3: begin
              if (!lane_q) begin
                lane_q <= 1'b1;
                step_q <= prgc_pkg::SP_A0;
              end else begin
                lane_q  <= 1'b0;
              end
            end
            default: begin
              step_q <= prgc_pkg::step_e'(step_q + 1'b1);
            end
          endcase
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept) begin
      meas_q[0] <= meas_alpha_i;
      meas_q[1] <= meas_beta_i;
      z_q       <= z_full[21:6];
      quad_q    <= phase_angle_i[PHASE_WIDTH-1 -: 2];
      freq_q    <= line_freq_i;
    end
    if (state_q == ST_ISSUE) neg_q <= mul_neg;
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      out_a_q <= volt_q[0];
      out_b_q <= volt_q[1];
    end
    if (state_q == ST_POST) begin
      case (step_q)
        prgc_pkg::SP_Z2: z2_q <= prod[32:16];
        prgc_pkg::SP_ZC: t_q  <= prgc_pkg::SIN_B - prod[31:16];
        prgc_pkg::SP_ZT: t2_q <= prgc_pkg::SIN_A - prod[32:16];
        prgc_pkg::SP_ZF: begin
          if (!lane_q) begin
            fz_q <= f_new;
          end else begin
            // Quadrant folding of the quarter-wave values.
            case (quad_q)
              prgc_pkg::QUAD_0: begin
                sn_q <= $signed({1'b0, fz_q}); cs_q <= $signed({1'b0, f_new});
              end
              prgc_pkg::QUAD_1: begin
                sn_q <= $signed({1'b0, f_new}); cs_q <= -$signed({1'b0, fz_q});
              end
              prgc_pkg::QUAD_2: begin
                sn_q <= -$signed({1'b0, fz_q}); cs_q <= -$signed({1'b0, f_new});
              end
              default: begin
                sn_q <= -$signed({1'b0, f_new}); cs_q <= $signed({1'b0, fz_q});
              end
            endcase
          end
        end
        prgc_pkg::SP_R0, prgc_pkg::SP_R2: acc_q <= RW'(sp);
        prgc_pkg::SP_R1: ref_a_q <= EW'((acc_n + RW'(32768)) >>> 16);
        prgc_pkg::SP_R3: ref_b_q <= EW'((acc_q + RW'(sp) + RW'(32768)) >>> 16);
        prgc_pkg::SP_W0: w_q    <= 40'(prod[31:0]);
        prgc_pkg::SP_W1: w_q    <= prod[63:24];
        prgc_pkg::SP_W2: w2dt_q <= prod[61:16];
        prgc_pkg::SP_A0: drive_q <= IW'(sat_sym(xv - SUM_W'(si_q[lane_q])));
        prgc_pkg::SP_A3: begin
          if (vv > V_MAX) volt_q[lane_q] <= 32'sh7fffffff;
          else if (vv < V_MIN) volt_q[lane_q] <= 32'sh80000000;
          else volt_q[lane_q] <= 32'(vv);
        end
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign volt_alpha_o = out_a_q;
  assign volt_beta_o  = out_b_q;

  `PRGC_ASSERT_IMP(a_mul_done_in_mul, clk_i, rst_ni, mul_done, state_q == ST_MUL, "multiplier finished outside its wait state")
  `PRGC_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_accept, state_q == ST_ISSUE && step_q == prgc_pkg::SP_Z2 && !lane_q, "accepted word did not start the sequence")
  `PRGC_ASSERT_IMP(a_fi0_sym, clk_i, rst_ni, 1'b1, fi_q[0] != I_MIN && fi_q[1] != I_MIN, "integrator left its symmetric range")
  `PRGC_ASSERT_NXT(a_out_loaded, clk_i, rst_ni, state_q == ST_OUT && (!out_valid_q || !out_stall_i), out_valid_o && state_q == ST_IDLE, "finished result not presented")

endmodule

// ===== tb/pr_grid_current_controller_tb.sv =====
// Self-checking testbench for the proportional-resonant grid current controller.
// Needs prgc_pkg and pr_grid_current_controller; reads no files.
`timescale 1ns / 1ps
module pr_grid_current_controller_tb;

  // One sample word as the block sees it on its input ports.
  typedef struct {
    logic signed [23:0] meas_alpha;
    logic signed [23:0] meas_beta;
    logic signed [23:0] want_d;
    logic signed [23:0] want_q;
    logic [15:0]        phase_angle;
    logic [15:0]        line_freq;
  } sample_t;

  // One voltage command word.
  typedef struct {
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
  } volt_t;

  typedef logic signed [127:0] wide_t;

  localparam longint INTEG_LIM = (64'sd1 <<< 47) - 1;
  localparam longint INT64_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [31:0] volt_alpha_o;
  logic signed [31:0] volt_beta_o;
  sample_t     cur_word;

  // Register copies and controller state of the predictor.
  logic [63:0] kp_reg, ki_reg, dt_reg, step_reg;
  longint      held_d, held_q;
  longint      integ1 [2];
  longint      integ2 [2];

  volt_t       pending_volts[$];
  int          fail_count;
  int          send_idle_pct;
  int          sink_stall_pct;
  int          hold_req;
  int          hold_left;
  logic [15:0] phase_acc;

  pr_grid_current_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .meas_alpha_i  (cur_word.meas_alpha),
    .meas_beta_i   (cur_word.meas_beta),
    .want_d_i      (cur_word.want_d),
    .want_q_i      (cur_word.want_q),
    .phase_angle_i (cur_word.phase_angle),
    .line_freq_i   (cur_word.line_freq),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .volt_alpha_o  (volt_alpha_o),
    .volt_beta_o   (volt_beta_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers of the predictor.
  // ---------------------------------------------------------------------------

  function automatic longint clamp_sym(wide_t x, longint lim);
    wide_t l;
    l = lim;
    if (x > l) return lim;
    if (x < -l) return -lim;
    return longint'(x);
  endfunction

  // Saturating sum; the operands never exceed the 64-bit range themselves.
  function automatic longint sat_sum(longint a, longint b, longint lim);
    wide_t ta, tb;
    ta = a;
    tb = b;
    return clamp_sym(ta + tb, lim);
  endfunction

  // |x| * u >> shift, truncated toward zero and saturated to +-lim.
  function automatic longint scaled_trunc(longint x, logic [63:0] u, int shift, longint lim);
    logic [63:0]  mag;
    logic [127:0] prod;
    longint       r;
    mag = (x < 0) ? -x : x;
    prod = ({64'd0, mag} * {64'd0, u}) >> shift;
    if (prod > 128'(lim)) r = lim;
    else r = longint'(prod[63:0]);
    return (x < 0) ? -r : r;
  endfunction

  // Quarter-wave sine polynomial, argument and result in Q16.
  function automatic longint quarter_wave(longint z);
    longint z2, t, t2;
    z2 = (z * z) >>> 16;
    t  = longint'(prgc_pkg::SIN_B) - ((z2 * longint'(prgc_pkg::SIN_C)) >>> 16);
    t2 = longint'(prgc_pkg::SIN_A) - ((z2 * t) >>> 16);
    return (z * t2) >>> 16;
  endfunction

  function automatic void clear_controller();
    held_d = 0;
    held_q = 0;
    for (int i = 0; i < 2; i++) begin
      integ1[i] = 0;
      integ2[i] = 0;
    end
  endfunction

  // Advances the controller by one sample and returns the voltage command.
  function automatic volt_t control_step(sample_t s);
    longint      meas [2];
    longint      refab [2];
    longint      dstep, z, fz, fc, sn, cs, err, drive, v;
    logic [63:0] freq, w2dt;
    volt_t       res;
    meas[0] = s.meas_alpha;
    meas[1] = s.meas_beta;
    dstep = clamp_sym(wide_t'(longint'(s.want_d) - held_d), longint'(step_reg));
    held_d += dstep;
    dstep = clamp_sym(wide_t'(longint'(s.want_q) - held_q), longint'(step_reg));
    held_q += dstep;

    z  = longint'({s.phase_angle[13:0], 2'b00});
    fz = quarter_wave(z);
    fc = quarter_wave(65536 - z);
    case (s.phase_angle[15:14])
      prgc_pkg::QUAD_0: begin sn = fz;  cs = fc;  end
      prgc_pkg::QUAD_1: begin sn = fc;  cs = -fz; end
      prgc_pkg::QUAD_2: begin sn = -fz; cs = -fc; end
      default:          begin sn = -fc; cs = fz;  end
    endcase
    refab[0] = (held_d * cs - held_q * sn + 32768) >>> 16;
    refab[1] = (held_d * sn + held_q * cs + 32768) >>> 16;

    freq = s.line_freq;
    w2dt = (((freq * freq * dt_reg) >> 24) * 64'(prgc_pkg::FOUR_PI_SQ)) >> 16;

    for (int i = 0; i < 2; i++) begin
      err   = refab[i] - meas[i];
      drive = sat_sum((err * longint'(ki_reg)) >>> 8, -integ2[i], INTEG_LIM);
      integ1[i] = sat_sum(integ1[i], scaled_trunc(drive, dt_reg, 32, INTEG_LIM), INTEG_LIM);
      integ2[i] = sat_sum(integ2[i], scaled_trunc(integ1[i], w2dt, 24, INTEG_LIM), INTEG_LIM);
      v = sat_sum((err * longint'(kp_reg)) >>> 8, integ1[i], INT64_TOP);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (i == 0) res.alpha = v[31:0];
      else res.beta = v[31:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: every accepted sample queues its predicted command, every
  // accepted result is compared with the oldest one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    volt_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_volts.size() == 0) begin
          $error("voltage word with nothing expected: alpha %0d beta %0d",
                 volt_alpha_o, volt_beta_o);
          fail_count++;
        end else begin
          want = pending_volts.pop_front();
          if (volt_alpha_o !== want.alpha) begin
            $error("volt_alpha expected %0d got %0d", want.alpha, volt_alpha_o);
            fail_count++;
          end
          if (volt_beta_o !== want.beta) begin
            $error("volt_beta expected %0d got %0d", want.beta, volt_beta_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_volts.push_back(control_step(cur_word));
    end
  end

  // Sink side: random stall at the phase's rate, or a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one word, with random idle cycles first, and waits for acceptance.
  // Valid stays high afterwards so back-to-back words leave no gap.
  task automatic send_word(sample_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_word   <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every command has come back, then lets the
  // sequencer settle before the configuration may change.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_volts.size() == 0);
    repeat (600) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      prgc_pkg::REG_PROP_GAIN: begin kp_reg = val[23:0]; clear_controller(); end
      prgc_pkg::REG_RES_GAIN:  begin ki_reg = val[23:0]; clear_controller(); end
      prgc_pkg::REG_PERIOD:    dt_reg = val;
      prgc_pkg::REG_MAX_STEP:  step_reg = val[22:0];
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      prgc_pkg::REG_PROP_GAIN: stored = kp_reg[31:0];
      prgc_pkg::REG_RES_GAIN:  stored = ki_reg[31:0];
      prgc_pkg::REG_PERIOD:    stored = dt_reg[31:0];
      default:                 stored = step_reg[31:0];
    endcase
    if (prdata !== stored) begin
      $error("prdata of register %0d expected %0h got %0h", idx, stored, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] dt,
                            logic [31:0] mstep);
    write_reg(prgc_pkg::REG_PROP_GAIN, kp);
    write_reg(prgc_pkg::REG_RES_GAIN, ki);
    write_reg(prgc_pkg::REG_PERIOD, dt);
    write_reg(prgc_pkg::REG_MAX_STEP, mstep);
  endtask

  function automatic sample_t make_word(logic signed [23:0] ma, logic signed [23:0] mb,
                                        logic signed [23:0] wd, logic signed [23:0] wq,
                                        logic [15:0] ph, logic [15:0] fr);
    sample_t w;
    w.meas_alpha  = ma;
    w.meas_beta   = mb;
    w.want_d      = wd;
    w.want_q      = wq;
    w.phase_angle = ph;
    w.line_freq   = fr;
    return w;
  endfunction

  // Most samples look like a running inverter: a phase that advances at
  // roughly grid rate, a frequency near 50 or 60 Hz and modest currents.
  // The rest are raw noise over every bit of every field.
  function automatic sample_t next_sample();
    sample_t w;
    if ($urandom_range(99) < 75) begin
      phase_acc += 16'($urandom_range(140, 200));
      w.phase_angle = phase_acc;
      w.line_freq   = ($urandom_range(1) ? 16'd12800 : 16'd15360)
                      + 16'($urandom_range(512)) - 16'd256;
      w.want_d      = 24'($signed($urandom_range(81920)) - 40960);
      w.want_q      = 24'($signed($urandom_range(81920)) - 40960);
      w.meas_alpha  = 24'($signed($urandom_range(81920)) - 40960);
      w.meas_beta   = 24'($signed($urandom_range(81920)) - 40960);
    end else begin
      w.phase_angle = 16'($urandom);
      w.line_freq   = 16'($urandom);
      w.want_d      = 24'($urandom);
      w.want_q      = 24'($urandom);
      w.meas_alpha  = 24'($urandom);
      w.meas_beta   = 24'($urandom);
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Defaults after reset: every quadrant boundary, field extremes and the
  // frequency range ends.
  task automatic test_reset_defaults();
    send_word(make_word(0, 0, 0, 0, 16'h0000, 16'd12800));
    send_word(make_word(0, 0, 24'sd4096, 0, 16'h3FFF, 16'd12800));
    send_word(make_word(0, 0, 24'sd4096, 24'sd4096, 16'h4000, 16'd12800));
    send_word(make_word(0, 0, -24'sd4096, 24'sd4096, 16'h8000, 16'd12800));
    send_word(make_word(0, 0, -24'sd4096, -24'sd4096, 16'hC000, 16'd0));
    send_word(make_word(0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    send_word(make_word(24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 16'h2000, 16'd12800));
    send_word(make_word(24'sh800000, 24'sh800000, 0, 0, 16'h6000, 16'd12800));
    send_word(make_word(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                        16'hA000, 16'hFFFF));
    drain();
  endtask

  // Register extremes: largest gains and period drive the integrators into
  // saturation and the commands into clamping; a zero period freezes them.
  task automatic test_register_extremes();
    set_config(32'hFFFFFF, 32'hFFFFFF, 32'hFFFF_FFFF, 32'h7FFFFF);
    send_word(make_word(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 16'h1234, 16'hFFFF));
    send_word(make_word(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 16'h9876, 16'hFFFF));
    send_word(make_word(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'h5555, 16'h8000));
    send_word(make_word(0, 0, 0, 0, 16'hEEEE, 16'd12800));
    drain();
    write_reg(prgc_pkg::REG_PERIOD, 32'd0);
    send_word(make_word(24'sd1000, -24'sd1000, 24'sd8192, 0, 16'h1000, 16'd12800));
    send_word(make_word(-24'sd5000, 24'sd300, 24'sd8192, 0, 16'h2000, 16'd12800));
    drain();
    set_config(32'd0, 32'd0, 32'd1, 32'd0);
    send_word(make_word(24'sd100, 24'sd200, 24'sh7FFFFF, 24'sh800000, 16'h4444, 16'd1));
    send_word(make_word(24'sh7FFFFF, 24'sh800000, 0, 0, 16'hC444, 16'hFFFF));
    drain();
  endtask

  // A gain write between runs of words clears held reference and
  // integrators.
  task automatic test_gain_clear();
    set_config(32'd25600, 32'd2048000, 32'd214748, 32'd410);
    repeat (4) send_word(make_word(24'sd500, -24'sd700, 24'sd20000, 24'sd9000,
                                   16'h3000, 16'd12800));
    drain();
    write_reg(prgc_pkg::REG_RES_GAIN, 32'd1024000);
    send_word(make_word(24'sd500, -24'sd700, 24'sd20000, 24'sd9000, 16'h3000, 16'd12800));
    drain();
    write_reg(prgc_pkg::REG_PROP_GAIN, 32'd51200);
    send_word(make_word(24'sd500, -24'sd700, 24'sd20000, 24'sd9000, 16'h3000, 16'd12800));
    drain();
  endtask

  // The sink holds off for a long stretch while the source keeps offering
  // words back to back, so the output register fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req = 3000;
    repeat (6) send_word(next_sample());
    drain();
  endtask

  // Random samples under four idling patterns, each with its own settings.
  task automatic test_random_phases();
    int send_pct [4] = '{0, 72, 0, 7};
    int sink_pct [4] = '{0, 0, 72, 7};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_config(32'd25600, 32'd2048000, 32'd214748, 32'd410);
        1: set_config($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                      $urandom, $urandom_range(23'h7FFFFF));
        2: set_config(32'd256, 32'd2560, 32'd429497, 32'h7FFFFF);
        default: set_config(32'd12800, 32'd512000, 32'd107374, 32'd1);
      endcase
      send_idle_pct  = send_pct[p];
      sink_stall_pct = sink_pct[p];
      repeat (160) send_word(next_sample());
      drain();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    cur_word       = make_word(0, 0, 0, 0, 0, 0);
    fail_count     = 0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    phase_acc      = '0;
    kp_reg   = 64'd25600;
    ki_reg   = 64'd2048000;
    dt_reg   = 64'd214748;
    step_reg = 64'd410;
    clear_controller();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_gain_clear();
    test_backpressure();
    test_random_phases();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
